[src/trms_pkg.sv]
// ----------------------------------------------------------------------------
// trms_pkg
// Shared types and constants of the three-phase windowed RMS core.
// ----------------------------------------------------------------------------
`default_nettype none

package trms_pkg;

  // Width and reset value of the window length register.
  localparam int                CFG_W        = 13;
  localparam logic [CFG_W-1:0]  WINDOW_RESET = 13'd300;

  typedef enum logic [1:0] {
    PH_A,
    PH_B,
    PH_C
  } phase_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_A,
    ST_SQ_B,
    ST_SQ_C,
    ST_ACC_C,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_SQRT_GO,
    ST_SQRT_WAIT,
    ST_OUT_WAIT
  } state_t;

  // Sequencer to datapath.
  typedef struct packed {
    logic   in_ready;
    logic   sq_en;
    phase_t sq_sel;
    logic   acc_en;
    phase_t acc_sel;
    logic   cnt_inc;
    logic   div_start;
    logic   sqrt_start;
    phase_t phase;
    logic   rms_load;
    logic   out_load;
  } trms_ctrl_t;

  // Datapath to sequencer.
  typedef struct packed {
    logic in_valid;
    logic win_done;
    logic div_done;
    logic sqrt_done;
    logic out_free;
  } trms_stat_t;

  function automatic phase_t next_phase(input phase_t p);
    phase_t n;
    unique case (p)
      PH_A:    n = PH_B;
      PH_B:    n = PH_C;
      default: n = PH_A;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

[src/three_phase_windowed_rms_core.sv]
// ----------------------------------------------------------------------------
// three_phase_windowed_rms_core
// Block RMS of three phase currents over a configurable window of samples.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake             Contents
//  in_      slave      in_tvalid/in_tready   phase a, b, c samples (signed)
//  out_     master     out_tvalid/out_tready rms a, b, c (unsigned)
//  cfg_     write      cfg_wen               window_length
//
//  A sample is accepted in ST_IDLE, then one shared multiplier squares the
//  phases in turn and the accumulators are updated in ST_SQ_A to ST_ACC_C.
//  A sample that closes the window then runs, phase by phase, the
//  bit-serial divider and square root that the three phases share. rst_n is
//  synchronous; it clears the sums, the count and all handshake state and
//  sets the window to 300 samples.
//  A stalled result is held in the output register while the next samples
//  are taken; only the next window end waits for it to drain.
// ----------------------------------------------------------------------------
`default_nettype none

module three_phase_windowed_rms_core
  import trms_pkg::*;
#(
  parameter  int SAMPLE_BITS = 16,
  parameter  int MAX_WINDOW  = 4096,
  localparam int DATA_W      = ((3 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // Fields from bit 0: phase_a_sample, phase_b_sample, phase_c_sample.
  input  wire logic [DATA_W-1:0] in_tdata,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  // Fields from bit 0: rms_a, rms_b, rms_c, then zero padding.
  output logic      [DATA_W-1:0] out_tdata,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  input  wire logic              cfg_wen,
  input  wire logic [CFG_W-1:0]  cfg_wdata
);

  localparam int SB      = SAMPLE_BITS;
  localparam int SQ_W    = 2 * SB;
  localparam int COUNT_W = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W   = 2 * SB - 1 + $clog2(MAX_WINDOW);
  localparam int EFF_W   = (COUNT_W > CFG_W) ? COUNT_W : CFG_W;

  trms_ctrl_t ctrl;
  trms_stat_t stat;

  logic [CFG_W-1:0]   wlen_r;
  logic [SB-1:0]      samp_a_r, samp_b_r, samp_c_r;
  logic [SQ_W-1:0]    sq_r;
  logic [SUM_W-1:0]   acc_a_r, acc_b_r, acc_c_r;
  logic [COUNT_W-1:0] cnt_r;
  logic [SB-1:0]      rms_a_r, rms_b_r, rms_c_r;
  logic [DATA_W-1:0]  out_tdata_r;
  logic               out_tvalid_r;

  logic [SB-1:0]      sel_s, mag;
  logic [SQ_W-1:0]    sq_nxt;
  logic [SUM_W-1:0]   acc_sel_v, acc_sum;
  logic [SUM_W-1:0]   div_num;
  logic [SUM_W-1:0]   quotient;
  logic [SB-1:0]      root;
  logic               div_done, sqrt_done;
  logic [EFF_W-1:0]   wlen_ext, eff_win, cnt_inc_ext;
  logic               in_acc;

  assign in_acc = in_tvalid && ctrl.in_ready;

  // Zero means one sample; lengths above the maximum saturate.
  always_comb begin
    wlen_ext = EFF_W'(wlen_r);
    if (wlen_ext == '0) begin
      eff_win = EFF_W'(1);
    end else if (wlen_ext > EFF_W'(MAX_WINDOW)) begin
      eff_win = EFF_W'(MAX_WINDOW);
    end else begin
      eff_win = wlen_ext;
    end
    cnt_inc_ext = EFF_W'(cnt_r) + EFF_W'(1);
  end

  always_comb begin
    unique case (ctrl.sq_sel)
      PH_A:    sel_s = samp_a_r;
      PH_B:    sel_s = samp_b_r;
      default: sel_s = samp_c_r;
    endcase
    // The most negative sample negates to itself, which read unsigned is right.
    mag    = sel_s[SB-1] ? SB'(~sel_s + 1'b1) : sel_s;
    sq_nxt = SQ_W'(mag) * SQ_W'(mag);
  end

  always_comb begin
    unique case (ctrl.acc_sel)
      PH_A:    acc_sel_v = acc_a_r;
      PH_B:    acc_sel_v = acc_b_r;
      default: acc_sel_v = acc_c_r;
    endcase
    acc_sum = acc_sel_v + SUM_W'(sq_r);
    unique case (ctrl.phase)
      PH_A:    div_num = acc_a_r;
      PH_B:    div_num = acc_b_r;
      default: div_num = acc_c_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r <= WINDOW_RESET;
    end else if (cfg_wen) begin
      wlen_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      samp_a_r <= in_tdata[SB-1:0];
      samp_b_r <= in_tdata[2*SB-1:SB];
      samp_c_r <= in_tdata[3*SB-1:2*SB];
    end
    if (ctrl.sq_en) begin
      sq_r <= sq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_a_r <= '0;
      acc_b_r <= '0;
      acc_c_r <= '0;
      cnt_r   <= '0;
    end else if (ctrl.out_load) begin
      acc_a_r <= '0;
      acc_b_r <= '0;
      acc_c_r <= '0;
      cnt_r   <= '0;
    end else begin
      if (ctrl.acc_en) begin
        unique case (ctrl.acc_sel)
          PH_A:    acc_a_r <= acc_sum;
          PH_B:    acc_b_r <= acc_sum;
          default: acc_c_r <= acc_sum;
        endcase
      end
      if (ctrl.cnt_inc) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  trms_div #(
    .NUM_W (SUM_W),
    .DEN_W (COUNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctrl.div_start),
    .dividend (div_num),
    .divisor  (cnt_r),
    .quotient (quotient),
    .done     (div_done)
  );

  // The mean never exceeds the largest square, so its low SQ_W bits are exact.
  trms_sqrt #(
    .ROOT_W (SB)
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctrl.sqrt_start),
    .radicand (quotient[SQ_W-1:0]),
    .root     (root),
    .done     (sqrt_done)
  );

  always_ff @(posedge clk) begin
    if (ctrl.rms_load) begin
      unique case (ctrl.phase)
        PH_A:    rms_a_r <= root;
        PH_B:    rms_b_r <= root;
        default: rms_c_r <= root;
      endcase
    end
    if (ctrl.out_load) begin
      out_tdata_r <= DATA_W'({rms_c_r, rms_b_r, rms_a_r});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (ctrl.out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_comb begin
    stat.in_valid  = in_tvalid;
    stat.win_done  = (cnt_inc_ext >= eff_win);
    stat.div_done  = div_done;
    stat.sqrt_done = sqrt_done;
    stat.out_free  = !out_tvalid_r || out_tready;
  end

  trms_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  assign in_tready  = ctrl.in_ready;
  assign out_tdata  = out_tdata_r;
  assign out_tvalid = out_tvalid_r;

  // A sample is squared and accumulated before the next one is taken.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again right after a transaction");

  // The count never runs past the largest window.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= COUNT_W'(MAX_WINDOW))
    else $error("sample count above maximum window");

  // A fresh result always comes with a cleared count and cleared sums of phases a and c.
  a_cleared_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> (cnt_r == '0) && (acc_a_r == '0) && (acc_c_r == '0))
    else $error("window state not cleared when result issued");

  // The divider only starts on a completed window.
  a_div_needs_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.div_start |-> (cnt_r != '0))
    else $error("divide started with an empty window");

endmodule

`default_nettype wire

[src/trms_div.sv]
// ----------------------------------------------------------------------------
// trms_div
// Restoring divider, one quotient bit per cycle, shared by the three phases.
// ----------------------------------------------------------------------------
`default_nettype none

module trms_div #(
  parameter int NUM_W = 43,
  parameter int DEN_W = 13
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] dividend,
  input  wire logic [DEN_W-1:0] divisor,
  output logic      [NUM_W-1:0] quotient,
  output logic                  done
);

  localparam int ITER_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]  quo_r, quo_nxt;
  logic [DEN_W-1:0]  rem_r, rem_nxt;
  logic [ITER_W-1:0] iter_r;
  logic              busy_r;
  logic              done_r;
  logic [DEN_W:0]    rem_sh;
  logic              ge;

  always_comb begin
    rem_sh  = {rem_r, quo_r[NUM_W-1]};
    ge      = (rem_sh >= {1'b0, divisor});
    rem_nxt = ge ? DEN_W'(rem_sh - {1'b0, divisor}) : rem_sh[DEN_W-1:0];
    quo_nxt = {quo_r[NUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      iter_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        iter_r <= ITER_W'(NUM_W);
      end else if (busy_r) begin
        iter_r <= iter_r - 1'b1;
        if (iter_r == ITER_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

`default_nettype wire

[src/trms_sqrt.sv]
// ----------------------------------------------------------------------------
// trms_sqrt
// Bit-serial floor square root, one root bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module trms_sqrt #(
  parameter int ROOT_W = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [2*ROOT_W-1:0] radicand,
  output logic      [ROOT_W-1:0]   root,
  output logic                     done
);

  localparam int ITER_W = $clog2(ROOT_W + 1);

  logic [2*ROOT_W-1:0] x_r;
  logic [ROOT_W:0]     rem_r, rem_nxt;
  logic [ROOT_W-1:0]   root_r;
  logic [ITER_W-1:0]   iter_r;
  logic                busy_r;
  logic                done_r;
  logic [ROOT_W+2:0]   rem_t;
  logic [ROOT_W+2:0]   trial;
  logic                ge;

  // The remainder never exceeds twice the partial root, so ROOT_W+1 bits hold it.
  always_comb begin
    rem_t   = {rem_r, x_r[2*ROOT_W-1 -: 2]};
    trial   = {1'b0, root_r, 2'b01};
    ge      = (rem_t >= trial);
    rem_nxt = ge ? (ROOT_W+1)'(rem_t - trial) : rem_t[ROOT_W:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      iter_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        iter_r <= ITER_W'(ROOT_W);
      end else if (busy_r) begin
        iter_r <= iter_r - 1'b1;
        if (iter_r == ITER_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      x_r    <= {x_r[2*ROOT_W-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= {root_r[ROOT_W-2:0], ge};
    end
  end

  assign root = root_r;
  assign done = done_r;

endmodule

`default_nettype wire

[src/trms_ctrl.sv]
// ----------------------------------------------------------------------------
// trms_ctrl
// Sequencer: square and accumulate per phase, then divide and root per phase.
// ----------------------------------------------------------------------------
`default_nettype none

module trms_ctrl
  import trms_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire trms_stat_t stat,
  output trms_ctrl_t      ctrl
);

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= PH_A;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    unique case (state_r)
      ST_IDLE:      if (stat.in_valid) state_nxt = ST_SQ_A;
      ST_SQ_A:      state_nxt = ST_SQ_B;
      ST_SQ_B:      state_nxt = ST_SQ_C;
      ST_SQ_C:      state_nxt = ST_ACC_C;
      ST_ACC_C:     state_nxt = stat.win_done ? ST_DIV_GO : ST_IDLE;
      ST_DIV_GO:    state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT:  if (stat.div_done) state_nxt = ST_SQRT_GO;
      ST_SQRT_GO:   state_nxt = ST_SQRT_WAIT;
      ST_SQRT_WAIT: begin
        if (stat.sqrt_done) begin
          state_nxt = (phase_r == PH_C) ? ST_OUT_WAIT : ST_DIV_GO;
          phase_nxt = (phase_r == PH_C) ? PH_A : next_phase(phase_r);
        end
      end
      ST_OUT_WAIT:  if (stat.out_free) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl         = '0;
    ctrl.sq_sel  = PH_A;
    ctrl.acc_sel = PH_A;
    ctrl.phase   = phase_r;
    unique case (state_r)
      ST_IDLE:      ctrl.in_ready = 1'b1;
      ST_SQ_A: begin
        ctrl.sq_en  = 1'b1;
        ctrl.sq_sel = PH_A;
      end
      ST_SQ_B: begin
        ctrl.acc_en  = 1'b1;
        ctrl.acc_sel = PH_A;
        ctrl.sq_en   = 1'b1;
        ctrl.sq_sel  = PH_B;
      end
      ST_SQ_C: begin
        ctrl.acc_en  = 1'b1;
        ctrl.acc_sel = PH_B;
        ctrl.sq_en   = 1'b1;
        ctrl.sq_sel  = PH_C;
      end
      ST_ACC_C: begin
        ctrl.acc_en  = 1'b1;
        ctrl.acc_sel = PH_C;
        ctrl.cnt_inc = 1'b1;
      end
      ST_DIV_GO:    ctrl.div_start  = 1'b1;
      ST_DIV_WAIT:  ;
      ST_SQRT_GO:   ctrl.sqrt_start = 1'b1;
      ST_SQRT_WAIT: ctrl.rms_load   = stat.sqrt_done;
      ST_OUT_WAIT:  ctrl.out_load   = stat.out_free;
      default:      ;
    endcase
  end

endmodule

`default_nettype wire

[test/trms_rms_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trms_rms_checker
// Watches the sample, result and window channels of the three-phase RMS
// core, keeps its own copy of the sums of squares, and checks every result.
// ----------------------------------------------------------------------------

module trms_rms_checker
  import trms_pkg::*;
#(
  parameter  int SAMPLE_BITS = 16,
  parameter  int MAX_WINDOW  = 4096,
  localparam int DATA_W      = ((3 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [DATA_W-1:0] in_tdata,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [DATA_W-1:0] out_tdata,
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic              cfg_wen,
  input  logic [CFG_W-1:0]  cfg_wdata,
  output int                fail_count,
  output int                rms_pending
);

  // One word per phase, phase a in the lowest bits as on both channels.
  typedef logic [2:0][SAMPLE_BITS-1:0] phase_word_t;

  logic [CFG_W-1:0]  window_len;
  longint unsigned   sum_sq [3];
  int unsigned       win_count;
  phase_word_t       rms_expected [$];
  int                failures = 0;

  function automatic longint unsigned square_of_current(input logic [SAMPLE_BITS-1:0] raw);
    longint value;
    value = longint'($signed(raw));
    return value * value;
  endfunction

  // Floor square root, settling one result bit at a time from the top.
  function automatic logic [SAMPLE_BITS-1:0] floor_root(input longint unsigned x);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = SAMPLE_BITS; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= x) root = trial;
    end
    return root[SAMPLE_BITS-1:0];
  endfunction

  function automatic int unsigned window_target(input logic [CFG_W-1:0] w);
    if (w == '0) return 1;
    if (w > MAX_WINDOW) return MAX_WINDOW;
    return w;
  endfunction

  function automatic string rms_field(input int p);
    string s;
    case (phase_t'(p))
      PH_A:    s = "rms_a";
      PH_B:    s = "rms_b";
      default: s = "rms_c";
    endcase
    return s;
  endfunction

  always @(posedge clk) begin : predict_and_compare
    phase_word_t currents;
    phase_word_t got;
    phase_word_t want;
    if (!rst_n) begin
      window_len = WINDOW_RESET;
      sum_sq     = '{default: 0};
      win_count  = 0;
      rms_expected.delete();
    end else begin
      // Results leave before the sample of this edge is predicted, so a result
      // can never be matched against an expectation created at the same edge.
      if (out_tvalid && out_tready) begin
        got = out_tdata[3*SAMPLE_BITS-1:0];
        if (rms_expected.size() == 0) begin
          $error("rms result with nothing expected: a=%0d b=%0d c=%0d",
                 got[0], got[1], got[2]);
          failures++;
        end else begin
          want = rms_expected.pop_front();
          for (int p = 0; p < 3; p++) begin
            if (got[p] !== want[p]) begin
              $error("%s mismatch: expected %0d, actual %0d", rms_field(p), want[p], got[p]);
              failures++;
            end
          end
        end
      end
      if (cfg_wen) window_len = cfg_wdata;
      if (in_tvalid && in_tready) begin
        currents = in_tdata[3*SAMPLE_BITS-1:0];
        for (int p = 0; p < 3; p++) sum_sq[p] += square_of_current(currents[p]);
        win_count++;
        // A shortened window closes as soon as the count reaches or passes it.
        if (win_count >= window_target(window_len)) begin
          for (int p = 0; p < 3; p++) begin
            want[p]   = floor_root(sum_sq[p] / win_count);
            sum_sq[p] = 0;
          end
          rms_expected = {rms_expected, want};
          win_count = 0;
        end
      end
    end
    fail_count  <= failures;
    rms_pending <= rms_expected.size();
  end

endmodule

[test/three_phase_windowed_rms_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_phase_windowed_rms_core_tb
// Drives three-phase current samples into the RMS core under many window
// lengths, with random gaps and back-pressure, and reports the verdict of
// the checker that watches the channels.
// ----------------------------------------------------------------------------

module three_phase_windowed_rms_core_tb
  import trms_pkg::*;
();

  localparam int SAMPLE_BITS    = 16;
  localparam int MAX_WINDOW     = 4096;
  localparam int DATA_W         = ((3 * SAMPLE_BITS + 7) / 8) * 8;
  // The settle time covers a closing sample's divide and square root for each phase in the core.
  localparam int SETTLE_CYCLES  = 300;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_ITEMS   = 150;
  localparam int TAIL_ITEMS     = 60;

  localparam logic [SAMPLE_BITS-1:0] MOST_NEG = 16'h8000;
  localparam logic [SAMPLE_BITS-1:0] MOST_POS = 16'h7FFF;
  localparam logic [CFG_W-1:0]       WINDOW_ALL_ONES = '1;

  logic              clk = 1'b0;
  logic              rst_n;
  logic [DATA_W-1:0] in_tdata;
  logic              in_tvalid;
  logic              in_tready;
  logic [DATA_W-1:0] out_tdata;
  logic              out_tvalid;
  logic              out_tready;
  logic              cfg_wen;
  logic [CFG_W-1:0]  cfg_wdata;

  int   fail_count;
  int   rms_pending;
  int   idle_cycles  = 0;
  logic src_idle_en  = 1'b0;
  logic sink_idle_en = 1'b0;
  logic hold_req     = 1'b0;
  logic hold_done    = 1'b0;

  always #5 clk = ~clk;

  three_phase_windowed_rms_core #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .MAX_WINDOW (MAX_WINDOW)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  trms_rms_checker #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .rms_pending(rms_pending)
  );

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("three_phase_windowed_rms_core regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: ready by default, random stall bursts, and one long hold-off
  // that lets the core fill up and stop taking samples.
  initial begin : rms_sink
    int unsigned stall_len;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        @(negedge clk);
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_tready <= 1'b1;
        hold_done = 1'b1;
      end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
        stall_len = $urandom_range(1, 8);
        @(negedge clk);
        out_tready <= 1'b0;
        repeat (stall_len) @(negedge clk);
        out_tready <= 1'b1;
      end else begin
        @(negedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  function automatic logic [SAMPLE_BITS-1:0] draw_current();
    logic [SAMPLE_BITS-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = MOST_NEG;
      1:       v = MOST_POS;
      2:       v = SAMPLE_BITS'($urandom_range(0, 15));
      3:       v = '0 - SAMPLE_BITS'($urandom_range(1, 16));
      default: v = SAMPLE_BITS'($urandom());
    endcase
    return v;
  endfunction

  // Called and returns at a falling edge; leaves in_tvalid high.
  task automatic offer_currents(input logic [SAMPLE_BITS-1:0] a,
                                input logic [SAMPLE_BITS-1:0] b,
                                input logic [SAMPLE_BITS-1:0] c);
    int unsigned gap;
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  <= {c, b, a};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic offer_random(input int unsigned n);
    repeat (n) offer_currents(draw_current(), draw_current(), draw_current());
  endtask

  task automatic set_window(input logic [CFG_W-1:0] w);
    cfg_wdata <= w;
    cfg_wen   <= 1'b1;
    @(negedge clk);
    cfg_wen   <= 1'b0;
    @(negedge clk);
  endtask

  // Wait for every predicted result, then for a sample without a result to
  // finish inside the core, so the window register may be written.
  task automatic wait_windows_closed();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (rms_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin : stimulus
    int unsigned sent;
    int unsigned n;
    int unsigned win;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_wen   <= 1'b0;
    cfg_wdata <= '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;

    // One full window at the reset length.
    offer_currents(MOST_POS, MOST_NEG, '0);
    offer_currents(MOST_NEG, MOST_POS, '1);
    offer_random(WINDOW_RESET - 2);
    wait_windows_closed();

    set_window(13'd1);
    offer_currents(MOST_POS, MOST_NEG, 16'h0000);
    offer_currents(MOST_NEG, MOST_POS, 16'hFFFF);
    offer_currents(16'hFFFF, 16'h0001, 16'h0000);
    offer_currents(16'h0000, 16'h0000, 16'h0000);
    offer_currents(MOST_NEG, MOST_NEG, MOST_NEG);
    offer_currents(MOST_POS, MOST_POS, MOST_POS);
    wait_windows_closed();

    // A zero window behaves as a window of one sample.
    set_window(13'd0);
    offer_currents(16'h3039, 16'hCFC7, MOST_NEG);
    offer_currents(16'h0001, 16'hFFFF, 16'h0002);
    wait_windows_closed();

    set_window(13'd2);
    offer_currents(MOST_POS, MOST_NEG, 16'h0064);
    offer_currents(MOST_NEG, MOST_POS, 16'hFF9C);
    wait_windows_closed();

    // Shorten the window below the samples already gathered.
    set_window(13'd6);
    offer_random(3);
    wait_windows_closed();
    set_window(13'd2);
    offer_random(1);
    wait_windows_closed();

    // Hold the result side off while samples keep coming.
    set_window(13'd1);
    hold_req = 1'b1;
    offer_random(16);
    wait_windows_closed();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      src_idle_en  = ($urandom_range(0, 3) != 0);
      sink_idle_en = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: win = $urandom_range(1, 8);
        6, 7:             win = $urandom_range(9, 40);
        8:                win = 0;
        default:          win = $urandom_range(41, 8191);
      endcase
      set_window(CFG_W'(win));
      // Long windows are left open; a later, shorter window closes them.
      if (win == 0 || win > 40) n = $urandom_range(1, 20);
      else n = $urandom_range(1, 3 * win + 2);
      if (n > RANDOM_ITEMS - sent) n = RANDOM_ITEMS - sent;
      offer_random(n);
      sent += n;
      wait_windows_closed();
    end

    // Last part without idling: flush any open window, gather samples with
    // the window written above the limit, then close it with a shorter one.
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    set_window(13'd1);
    offer_random(1);
    wait_windows_closed();
    set_window(WINDOW_ALL_ONES);
    repeat (TAIL_ITEMS) offer_currents(MOST_NEG, MOST_POS, draw_current());
    wait_windows_closed();
    set_window(13'd1);
    offer_random(1);
    wait_windows_closed();

    if (fail_count == 0) begin
      $display("three_phase_windowed_rms_core regression: pass");
    end else begin
      $display("three_phase_windowed_rms_core regression: fail");
    end
    $finish;
  end

endmodule

[sim.f]
src/trms_pkg.sv
src/trms_div.sv
src/trms_sqrt.sv
src/trms_ctrl.sv
src/three_phase_windowed_rms_core.sv
test/trms_rms_checker.sv
test/three_phase_windowed_rms_core_tb.sv
